// File: rtl/smac_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine ALU package
// Shared constants, opcode and status codes, and the command and status
// structs that connect the controller to the datapath.
// ----------------------------------------------------------------------------
package smac_pkg;

  // Stack and word geometry.
  localparam int STACK_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_OUT_W = 5;
  localparam int DIV_CNT_W   = $clog2(WORD_W);

  // Field widths.
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;

  // Opcodes.
  localparam logic [CMD_W-1:0] OP_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] OP_POP  = 3'd1;
  localparam logic [CMD_W-1:0] OP_ADD  = 3'd2;
  localparam logic [CMD_W-1:0] OP_SUB  = 3'd3;
  localparam logic [CMD_W-1:0] OP_MUL  = 3'd4;
  localparam logic [CMD_W-1:0] OP_DIV  = 3'd5;
  localparam logic [CMD_W-1:0] OP_HLT  = 3'd6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd5;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                push;
    logic                pop_last;
    logic                rd_en;
    logic                pop_wb;
    logic                alu_wb;
    logic                mul_run;
    logic                mul_wb;
    logic                div_load;
    logic                div_step;
    logic                div_wb;
    logic                stop;
    logic                st_we;
    logic [STATUS_W-1:0] st_code;
  } smac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             stopped;
    logic             sp_zero;
    logic             sp_one;
    logic             sp_full;
    logic             b_zero;
    logic             div_last;
  } smac_stat_t;

endpackage

// File: rtl/stack_machine_alu_core.sv
// ----------------------------------------------------------------------------
// Stack machine ALU core
// Executes one stack instruction per request and reports status, the new
// top of stack and the stack depth.
// ----------------------------------------------------------------------------
// Usage: a request (cmd, push_value) is taken on a rising edge with start
// high and busy low. busy stays high until the response has been shown.
// The response (status, top_value, stack_depth) is valid for exactly one
// cycle while done is high; the receiver must take it then, it cannot
// stall the core.
// Paths from decode to the response: push, a pop of the last word, halt, an
// unknown opcode, a stopped machine, a full push, an empty pop and too few
// operands answer straight from decode; any other pop passes through the pop
// write-back state, add, sub and a divide by zero through the operand read,
// mul through operand read and its product register, and div through operand
// read, the 32-step radix-2 divider and its write-back. The core is ready
// again the cycle after done. Reads of the word below the top pass through
// the stack RAM's registered read port.
// Reset (rst, synchronous) empties the stack, clears the stopped flag and
// returns to idle. Once halted, or after too few operands or an unknown
// opcode, every request answers with the stopped status until reset.
// ----------------------------------------------------------------------------
module stack_machine_alu_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [smac_pkg::CMD_W-1:0]         cmd,
  input  logic signed [smac_pkg::WORD_W-1:0] push_value,
  output logic                               done,
  output logic [smac_pkg::STATUS_W-1:0]      status,
  output logic signed [smac_pkg::WORD_W-1:0] top_value,
  output logic [smac_pkg::DEPTH_OUT_W-1:0]   stack_depth
);

  smac_pkg::smac_cmd_t  ctl;
  smac_pkg::smac_stat_t stat;

  // Instruction sequencer.
  smac_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // Stack storage and arithmetic.
  smac_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cmd         (cmd),
    .push_value  (push_value),
    .stat        (stat),
    .status      (status),
    .top_value   (top_value),
    .stack_depth (stack_depth)
  );

endmodule

// File: rtl/smac_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/smac_ctrl.sv
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences one instruction: decode, operand read, execute and response.
// ----------------------------------------------------------------------------
module smac_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  smac_pkg::smac_stat_t stat,
  output smac_pkg::smac_cmd_t  ctl,
  output logic                 busy,
  output logic                 done
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_OPREAD = 3'd2;
  localparam logic [2:0] S_POPWB  = 3'd3;
  localparam logic [2:0] S_MULWB  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DIVWB  = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.st_we   = 1'b1;
        ctl.st_code = smac_pkg::ST_OK;
        state_next  = S_RESP;
        if (stat.stopped) begin
          ctl.st_code = smac_pkg::ST_STOPPED;
        end else begin
          unique case (stat.cmd)
            smac_pkg::OP_PUSH: begin
              if (stat.sp_full) begin
                ctl.st_code = smac_pkg::ST_FULL;
              end else begin
                ctl.push = 1'b1;
              end
            end
            smac_pkg::OP_POP: begin
              if (stat.sp_zero) begin
                ctl.st_code = smac_pkg::ST_EMPTY;
              end else if (stat.sp_one) begin
                ctl.pop_last = 1'b1;
              end else begin
                ctl.rd_en  = 1'b1;
                state_next = S_POPWB;
              end
            end
            smac_pkg::OP_ADD, smac_pkg::OP_SUB, smac_pkg::OP_MUL,
            smac_pkg::OP_DIV: begin
              if (stat.sp_zero || stat.sp_one) begin
                ctl.st_code = smac_pkg::ST_FEW;
                ctl.stop    = 1'b1;
              end else begin
                ctl.rd_en  = 1'b1;
                state_next = S_OPREAD;
              end
            end
            smac_pkg::OP_HLT: begin
              ctl.stop = 1'b1;
            end
            default: begin
              ctl.st_code = smac_pkg::ST_UNKNOWN;
              ctl.stop    = 1'b1;
            end
          endcase
        end
      end
      S_POPWB: begin
        ctl.pop_wb = 1'b1;
        state_next = S_RESP;
      end
      S_OPREAD: begin
        // The lower operand is now on the RAM read port.
        unique case (stat.cmd)
          smac_pkg::OP_ADD, smac_pkg::OP_SUB: begin
            ctl.alu_wb = 1'b1;
            state_next = S_RESP;
          end
          smac_pkg::OP_MUL: begin
            ctl.mul_run = 1'b1;
            state_next  = S_MULWB;
          end
          default: begin
            if (stat.b_zero) begin
              ctl.st_we   = 1'b1;
              ctl.st_code = smac_pkg::ST_DIVZERO;
              state_next  = S_RESP;
            end else begin
              ctl.div_load = 1'b1;
              state_next   = S_DIV;
            end
          end
        endcase
      end
      S_MULWB: begin
        ctl.mul_wb = 1'b1;
        state_next = S_RESP;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_DIVWB;
        end
      end
      S_DIVWB: begin
        ctl.div_wb = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

// File: rtl/smac_dp.sv
// ----------------------------------------------------------------------------
// Stack machine datapath
// Holds the top of stack in a register and the words below it in a RAM,
// with the adder, the multiplier and a restoring radix-2 divider.
// ----------------------------------------------------------------------------
module smac_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smac_pkg::smac_cmd_t                  ctl,
  input  logic [smac_pkg::CMD_W-1:0]           cmd,
  input  logic signed [smac_pkg::WORD_W-1:0]   push_value,
  output smac_pkg::smac_stat_t                 stat,
  output logic [smac_pkg::STATUS_W-1:0]        status,
  output logic signed [smac_pkg::WORD_W-1:0]   top_value,
  output logic [smac_pkg::DEPTH_OUT_W-1:0]     stack_depth
);

  localparam int W = smac_pkg::WORD_W;

  logic [smac_pkg::SP_W-1:0]        sp;
  logic                             stopped;
  logic [smac_pkg::CMD_W-1:0]       cmd_q;
  logic [W-1:0]                     val_q;
  logic [W-1:0]                     top;
  logic [smac_pkg::STATUS_W-1:0]    st_q;
  logic [W-1:0]                     prod;
  logic [W-1:0]                     rem;
  logic [W-1:0]                     quo;
  logic [W-1:0]                     dvs;
  logic                             neg;
  logic [smac_pkg::DIV_CNT_W-1:0]   cnt;

  logic [smac_pkg::SP_W-1:0]        sp_m1;
  logic [smac_pkg::SP_W-1:0]        sp_m2;
  logic [W-1:0]                     rdata;
  logic [W-1:0]                     mul_lo;
  logic [W:0]                       shl;
  logic [W:0]                       trial;
  logic [W-1:0]                     mag_a;
  logic [W-1:0]                     mag_b;
  logic [W-1:0]                     alu_res;
  logic [smac_pkg::SP_W+smac_pkg::DEPTH_OUT_W-1:0] sp_ext;

  assign sp_m1 = sp - smac_pkg::SP_W'(1);
  assign sp_m2 = sp - smac_pkg::SP_W'(2);

  // Words below the top of stack live in the RAM; a push spills the old top.
  smac_ram #(
    .WIDTH (W),
    .DEPTH (smac_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push && (sp != '0)),
    .waddr (sp_m1[smac_pkg::ADDR_W-1:0]),
    .wdata (top),
    .re    (ctl.rd_en),
    .raddr (sp_m2[smac_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Add or subtract with the lower word as the first operand; the product
  // keeps its low word only.
  assign alu_res = (cmd_q == smac_pkg::OP_SUB) ? (rdata - top) : (rdata + top);
  assign mul_lo  = rdata * top;

  // Operand magnitudes for the divider.
  assign mag_a = rdata[W-1] ? (W'(0) - rdata) : rdata;
  assign mag_b = top[W-1] ? (W'(0) - top) : top;

  // One restoring division step.
  assign shl   = {rem, quo[W-1]};
  assign trial = shl - {1'b0, dvs};

  // Stack pointer and stop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      stopped <= 1'b0;
    end else begin
      if (ctl.push) begin
        sp <= sp + smac_pkg::SP_W'(1);
      end else if (ctl.pop_last || ctl.pop_wb || ctl.alu_wb || ctl.mul_wb ||
                   ctl.div_wb) begin
        sp <= sp_m1;
      end
      if (ctl.stop) begin
        stopped <= 1'b1;
      end
    end
  end

  // Request latch, top of stack, status and arithmetic registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      val_q <= push_value;
    end
    if (ctl.st_we) begin
      st_q <= ctl.st_code;
    end
    if (ctl.push) begin
      top <= val_q;
    end else if (ctl.pop_wb) begin
      top <= rdata;
    end else if (ctl.alu_wb) begin
      top <= alu_res;
    end else if (ctl.mul_wb) begin
      top <= prod;
    end else if (ctl.div_wb) begin
      top <= neg ? (W'(0) - quo) : quo;
    end
    if (ctl.mul_run) begin
      prod <= mul_lo;
    end
    if (ctl.div_load) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= rdata[W-1] ^ top[W-1];
      cnt <= '0;
    end else if (ctl.div_step) begin
      rem <= trial[W] ? shl[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], ~trial[W]};
      cnt <= cnt + smac_pkg::DIV_CNT_W'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat          = '0;
    stat.cmd      = cmd_q;
    stat.stopped  = stopped;
    stat.sp_zero  = (sp == '0);
    stat.sp_one   = (sp == smac_pkg::SP_W'(1));
    stat.sp_full  = (sp == smac_pkg::SP_W'(smac_pkg::STACK_DEPTH));
    stat.b_zero   = (top == '0);
    stat.div_last = (cnt == {smac_pkg::DIV_CNT_W{1'b1}});
  end

  // Result fields.
  assign sp_ext      = {{smac_pkg::DEPTH_OUT_W{1'b0}}, sp};
  assign status      = st_q;
  assign top_value   = (sp == '0) ? '0 : top;
  assign stack_depth = sp_ext[smac_pkg::DEPTH_OUT_W-1:0];

endmodule

// File: rtl/smac_chk.sv
// ----------------------------------------------------------------------------
// Stack machine ALU checker
// Port-level checks on the request and response behavior of the core.
// ----------------------------------------------------------------------------
module smac_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic [smac_pkg::STATUS_W-1:0]      status,
  input logic signed [smac_pkg::WORD_W-1:0] top_value,
  input logic [smac_pkg::DEPTH_OUT_W-1:0]   stack_depth
);

  // An accepted request makes the core busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("core not busy after an accepted request");

  // A response ends the request and frees the core.
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy ##1 !busy))
    else $error("core not freed right after the response");

  // A full stack is reported only at full depth.
  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    (done && (status == smac_pkg::ST_FULL)) |->
      (stack_depth == smac_pkg::DEPTH_OUT_W'(smac_pkg::STACK_DEPTH)))
    else $error("full status with a stack that is not full");

  // An empty stack reports depth zero and a zero top.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == smac_pkg::ST_EMPTY)) |->
      ((stack_depth == '0) && (top_value == '0)))
    else $error("empty status with words on the stack");

endmodule

bind stack_machine_alu_core smac_chk u_smac_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .top_value   (top_value),
  .stack_depth (stack_depth)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack machine ALU core testbench
// Sends stack instructions through the start/busy request handshake. A
// local stack model predicts status, top of stack and depth for every
// accepted request, and each done strobe is checked against the oldest
// prediction. Directed corner cases come first, then random instruction
// sequences under varying sender gaps, and finally the stopped machine.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [smac_pkg::CMD_W-1:0]  OP_UNKNOWN  = 3'd7;
  localparam logic [smac_pkg::WORD_W-1:0] WORD_MIN    = 32'h8000_0000;
  localparam logic [smac_pkg::WORD_W-1:0] WORD_MAX    = 32'h7fff_ffff;
  localparam int                          CYCLE_LIMIT = 600000;

  typedef struct {
    logic [smac_pkg::STATUS_W-1:0]    status;
    logic [smac_pkg::WORD_W-1:0]      top;
    logic [smac_pkg::DEPTH_OUT_W-1:0] depth;
  } stack_result_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic [smac_pkg::CMD_W-1:0]          cmd = smac_pkg::OP_PUSH;
  logic signed [smac_pkg::WORD_W-1:0]  push_value = '0;
  logic                                done;
  logic [smac_pkg::STATUS_W-1:0]       status;
  logic signed [smac_pkg::WORD_W-1:0]  top_value;
  logic [smac_pkg::DEPTH_OUT_W-1:0]    stack_depth;

  // Local copy of the machine state, updated at each accepted request.
  logic [smac_pkg::WORD_W-1:0] model_words [smac_pkg::STACK_DEPTH];
  int                          model_sp = 0;
  logic                        model_stopped = 1'b0;

  stack_result_t pending_results[$];
  stack_result_t oldest_result;
  int            failures = 0;
  int            results_seen = 0;
  int            requests_sent = 0;
  int            sender_idle_pct = 0;
  int            cycle_count = 0;

  stack_machine_alu_core uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .push_value  (push_value),
    .done        (done),
    .status      (status),
    .top_value   (top_value),
    .stack_depth (stack_depth)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Executes one instruction on the local stack and returns the response.
  function automatic stack_result_t execute_instruction(
      input logic [smac_pkg::CMD_W-1:0] op, input logic [smac_pkg::WORD_W-1:0] val);
    stack_result_t r;
    logic [smac_pkg::WORD_W-1:0] a, b, q, mag_a, mag_b;
    logic                        write_back;
    r.status = smac_pkg::ST_OK;
    q = '0;
    if (model_stopped) begin
      r.status = smac_pkg::ST_STOPPED;
    end else begin
      case (op)
        smac_pkg::OP_PUSH: begin
          if (model_sp >= smac_pkg::STACK_DEPTH) begin
            r.status = smac_pkg::ST_FULL;
          end else begin
            model_words[model_sp] = val;
            model_sp++;
          end
        end
        smac_pkg::OP_POP: begin
          if (model_sp == 0) r.status = smac_pkg::ST_EMPTY;
          else model_sp--;
        end
        smac_pkg::OP_ADD, smac_pkg::OP_SUB, smac_pkg::OP_MUL, smac_pkg::OP_DIV: begin
          if (model_sp < 2) begin
            r.status = smac_pkg::ST_FEW;
            model_stopped = 1'b1;
          end else begin
            // The top word is the second operand, the one below it the first.
            b = model_words[model_sp-1];
            a = model_words[model_sp-2];
            write_back = 1'b1;
            case (op)
              smac_pkg::OP_ADD: q = a + b;
              smac_pkg::OP_SUB: q = a - b;
              smac_pkg::OP_MUL: q = a * b;
              default: begin
                if (b == '0) begin
                  write_back = 1'b0;
                  r.status = smac_pkg::ST_DIVZERO;
                end else begin
                  // Divide magnitudes, then fix the sign; truncates toward zero.
                  mag_a = a[smac_pkg::WORD_W-1] ? -a : a;
                  mag_b = b[smac_pkg::WORD_W-1] ? -b : b;
                  q = mag_a / mag_b;
                  if (a[smac_pkg::WORD_W-1] != b[smac_pkg::WORD_W-1]) q = -q;
                end
              end
            endcase
            if (write_back) begin
              model_sp--;
              model_words[model_sp-1] = q;
            end
          end
        end
        smac_pkg::OP_HLT: model_stopped = 1'b1;
        default: begin
          r.status = smac_pkg::ST_UNKNOWN;
          model_stopped = 1'b1;
        end
      endcase
    end
    r.top   = (model_sp == 0) ? '0 : model_words[model_sp-1];
    r.depth = model_sp[smac_pkg::DEPTH_OUT_W-1:0];
    return r;
  endfunction

  // Random word, weighted toward the corner values.
  function automatic logic [smac_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return WORD_MIN;
      3: return WORD_MAX;
      4: return 32'd1;
      5: return smac_pkg::WORD_W'($signed($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Sends one request, with an optional gap first, and records the response
  // it should produce once the core has accepted it.
  task automatic send_request(input logic [smac_pkg::CMD_W-1:0] op,
                              input logic [smac_pkg::WORD_W-1:0] val);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start      = 1'b1;
    cmd        = op;
    push_value = val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(execute_instruction(op, val));
    requests_sent++;
  endtask

  // Drops start and holds off until every response has come back.
  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Response checker: one expected response per done strobe.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected response: status %0d top %0d depth %0d",
                   status, top_value, stack_depth);
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.status || top_value !== oldest_result.top ||
            stack_depth !== oldest_result.depth) begin
          failures++;
          if (failures <= 10)
            $display("response %0d: expected status %0d top %0d depth %0d, got %0d %0d %0d",
                     results_seen, oldest_result.status, $signed(oldest_result.top),
                     oldest_result.depth, status, top_value, stack_depth);
        end
      end
    end
  end

  // Corner cases: empty pop, divide overflow, divide by zero, wrapping
  // add, sub and mul, and truncating division of negative values.
  task automatic test_corner_cases();
    sender_idle_pct = 19;
    send_request(smac_pkg::OP_POP, WORD_MAX);
    send_request(smac_pkg::OP_PUSH, WORD_MIN);
    send_request(smac_pkg::OP_PUSH, '1);
    send_request(smac_pkg::OP_DIV, '0);
    send_request(smac_pkg::OP_PUSH, '0);
    send_request(smac_pkg::OP_DIV, WORD_MIN);
    send_request(smac_pkg::OP_POP, '0);
    send_request(smac_pkg::OP_PUSH, WORD_MAX);
    send_request(smac_pkg::OP_PUSH, 32'd1);
    send_request(smac_pkg::OP_ADD, '0);
    send_request(smac_pkg::OP_PUSH, -32'sd7);
    send_request(smac_pkg::OP_PUSH, 32'd2);
    send_request(smac_pkg::OP_DIV, '0);
    send_request(smac_pkg::OP_PUSH, WORD_MAX);
    send_request(smac_pkg::OP_MUL, '0);
    send_request(smac_pkg::OP_PUSH, WORD_MAX);
    send_request(smac_pkg::OP_SUB, '0);
    wait_for_results();
  endtask

  // Random instruction sequences: mostly operand pushes followed by an
  // arithmetic instruction, plus runs that fill or drain the stack, and
  // single random instructions. Nothing here stops the machine.
  task automatic run_random_sequences(input int request_count, input int idle_pct);
    int first;
    int pick;
    logic [smac_pkg::CMD_W-1:0] op;
    sender_idle_pct = idle_pct;
    first = requests_sent;
    while (requests_sent - first < request_count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // Fill to the top and push past it.
        while (model_sp < smac_pkg::STACK_DEPTH) send_request(smac_pkg::OP_PUSH, pick_word());
        repeat ($urandom_range(1, 2)) send_request(smac_pkg::OP_PUSH, pick_word());
      end else if (pick < 12) begin
        // Drain to empty and pop once more.
        while (model_sp > 0) send_request(smac_pkg::OP_POP, pick_word());
        send_request(smac_pkg::OP_POP, pick_word());
      end else if (pick < 60) begin
        // Operands, then one arithmetic instruction.
        while (model_sp < 2) send_request(smac_pkg::OP_PUSH, pick_word());
        if ($urandom_range(1)) send_request(smac_pkg::OP_PUSH, pick_word());
        op = smac_pkg::OP_ADD + smac_pkg::CMD_W'($urandom_range(3));
        send_request(op, pick_word());
      end else begin
        op = smac_pkg::CMD_W'($urandom_range(smac_pkg::OP_DIV));
        if (op >= smac_pkg::OP_ADD && model_sp < 2) op = smac_pkg::OP_PUSH;
        send_request(op, pick_word());
      end
    end
  endtask

  task automatic test_random_mix();
    run_random_sequences(650, 19);
    wait_for_results();
    run_random_sequences(650, 57);
    wait_for_results();
    run_random_sequences(650, 0);
  endtask

  // Single requests, each waiting for its response before the next.
  task automatic test_paced_requests();
    sender_idle_pct = 0;
    repeat (10) begin
      if (model_sp < 2) send_request(smac_pkg::OP_PUSH, pick_word());
      else send_request(smac_pkg::OP_ADD + smac_pkg::CMD_W'($urandom_range(3)), pick_word());
      wait_for_results();
    end
  endtask

  // Stops the machine by halt, an unknown opcode or too few operands,
  // then checks that every opcode is ignored afterwards.
  task automatic test_stopped_machine();
    sender_idle_pct = 19;
    case ($urandom_range(2))
      0: send_request(smac_pkg::OP_HLT, pick_word());
      1: send_request(OP_UNKNOWN, pick_word());
      default: begin
        while (model_sp >= 2) send_request(smac_pkg::OP_POP, pick_word());
        if ($urandom_range(1)) send_request(smac_pkg::OP_POP, pick_word());
        send_request(smac_pkg::OP_ADD + smac_pkg::CMD_W'($urandom_range(3)), pick_word());
      end
    endcase
    for (int c = 0; c < 8; c++) send_request(smac_pkg::CMD_W'(c), pick_word());
    repeat (8) send_request(smac_pkg::CMD_W'($urandom_range(7)), pick_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_cases();
    test_random_mix();
    test_paced_requests();
    test_stopped_machine();
    wait_for_results();
    // Let a stray late response show up before judging.
    repeat (40) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
